[design/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define RDMC_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("rdmc: same-cycle check failed");

// next-cycle implication, disabled during reset
`define RDMC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("rdmc: next-cycle check failed");

`endif

[design/rdmc_pkg.sv]
package rdmc_pkg;

   localparam int DEF_MAZE_SIDE = 16;

   localparam logic [1:0] CMD_START = 2'd0;
   localparam logic [1:0] CMD_STEP  = 2'd1;
   localparam logic [1:0] CMD_READ  = 2'd2;

   localparam logic [2:0] ACT_CARVED    = 3'd0;
   localparam logic [2:0] ACT_BACKTRACK = 3'd1;
   localparam logic [2:0] ACT_NOP       = 3'd2;
   localparam logic [2:0] ACT_STARTED   = 3'd3;
   localparam logic [2:0] ACT_READ      = 3'd4;

   localparam logic [1:0] DIR_N = 2'd0;
   localparam logic [1:0] DIR_E = 2'd1;
   localparam logic [1:0] DIR_S = 2'd2;
   localparam logic [1:0] DIR_W = 2'd3;

   localparam logic [4:0] OPEN_N     = 5'h01;
   localparam logic [4:0] OPEN_E     = 5'h02;
   localparam logic [4:0] OPEN_S     = 5'h04;
   localparam logic [4:0] OPEN_W     = 5'h08;
   localparam logic [4:0] VISIT_MARK = 5'h10;

   // floor(r/3) = (r * RECIP3) >> RECIP3_SHIFT for any 16-bit r
   localparam logic [15:0] RECIP3       = 16'd43691;
   localparam int          RECIP3_SHIFT = 17;

   localparam int UPC_W = 5;

   localparam logic [UPC_W-1:0] U_IDLE    = 5'd0;
   localparam logic [UPC_W-1:0] U_CLR     = 5'd1;
   localparam logic [UPC_W-1:0] U_CLR_END = 5'd2;
   localparam logic [UPC_W-1:0] U_START   = 5'd3;
   localparam logic [UPC_W-1:0] U_STEP    = 5'd4;
   localparam logic [UPC_W-1:0] U_RD_N    = 5'd5;
   localparam logic [UPC_W-1:0] U_RD_E    = 5'd6;
   localparam logic [UPC_W-1:0] U_RD_S    = 5'd7;
   localparam logic [UPC_W-1:0] U_RD_W    = 5'd8;
   localparam logic [UPC_W-1:0] U_CAP_W   = 5'd9;
   localparam logic [UPC_W-1:0] U_CHOOSE  = 5'd10;
   localparam logic [UPC_W-1:0] U_WR_NB   = 5'd11;
   localparam logic [UPC_W-1:0] U_WR_TOP  = 5'd12;
   localparam logic [UPC_W-1:0] U_POP     = 5'd13;
   localparam logic [UPC_W-1:0] U_POP_LD  = 5'd14;
   localparam logic [UPC_W-1:0] U_READ    = 5'd15;
   localparam logic [UPC_W-1:0] U_RD_ANS  = 5'd16;
   localparam logic [UPC_W-1:0] U_NOP     = 5'd17;

   localparam logic [1:0] CM_NONE  = 2'd0;
   localparam logic [1:0] CM_READ  = 2'd1;
   localparam logic [1:0] CM_WRITE = 2'd2;

   localparam logic [3:0] A_CLR   = 4'd0;
   localparam logic [3:0] A_START = 4'd1;
   localparam logic [3:0] A_TOP   = 4'd2;
   localparam logic [3:0] A_N     = 4'd3;
   localparam logic [3:0] A_E     = 4'd4;
   localparam logic [3:0] A_S     = 4'd5;
   localparam logic [3:0] A_W     = 4'd6;
   localparam logic [3:0] A_NB    = 4'd7;
   localparam logic [3:0] A_READ  = 4'd8;

   localparam logic [1:0] W_ZERO    = 2'd0;
   localparam logic [1:0] W_VISITED = 2'd1;
   localparam logic [1:0] W_NB      = 2'd2;
   localparam logic [1:0] W_TOP     = 2'd3;

   localparam logic [2:0] CAP_NONE = 3'd0;
   localparam logic [2:0] CAP_TOP  = 3'd1;
   localparam logic [2:0] CAP_N    = 3'd2;
   localparam logic [2:0] CAP_E    = 3'd3;
   localparam logic [2:0] CAP_S    = 3'd4;
   localparam logic [2:0] CAP_W    = 3'd5;

   localparam logic [2:0] OP_NONE    = 3'd0;
   localparam logic [2:0] OP_CLR_INC = 3'd1;
   localparam logic [2:0] OP_START   = 3'd2;
   localparam logic [2:0] OP_CHOOSE  = 3'd3;
   localparam logic [2:0] OP_PUSH    = 3'd4;
   localparam logic [2:0] OP_POP_RD  = 3'd5;
   localparam logic [2:0] OP_POP_LD  = 3'd6;
   localparam logic [2:0] OP_RD_ANS  = 3'd7;

   localparam logic [2:0] J_NEXT      = 3'd0;
   localparam logic [2:0] J_ALWAYS    = 3'd1;
   localparam logic [2:0] J_CLR_MORE  = 3'd2;
   localparam logic [2:0] J_BOOT      = 3'd3;
   localparam logic [2:0] J_SKIP      = 3'd4;
   localparam logic [2:0] J_MASK_ZERO = 3'd5;

   typedef struct packed {
      logic [1:0]       cm;
      logic [3:0]       asel;
      logic [1:0]       wsel;
      logic [2:0]       cap;
      logic [2:0]       op;
      logic             emit;
      logic [2:0]       act;
      logic [2:0]       jcond;
      logic [UPC_W-1:0] target;
   } uword_type;

   typedef struct packed {
      logic clr_more;
      logic skip;
      logic mask_zero;
   } ucond_type;

   // cell reads are registered, so each step captures the read of the previous step
   function automatic uword_type ucode(input logic [UPC_W-1:0] upc);
      uword_type w;
      w = '{cm: CM_NONE, asel: A_TOP, wsel: W_ZERO, cap: CAP_NONE, op: OP_NONE,
            emit: 1'b0, act: ACT_NOP, jcond: J_NEXT, target: U_IDLE};
      case (upc)
         U_CLR: begin
            w.cm = CM_WRITE; w.asel = A_CLR; w.wsel = W_ZERO; w.op = OP_CLR_INC;
            w.jcond = J_CLR_MORE; w.target = U_CLR;
         end
         U_CLR_END: begin
            w.jcond = J_BOOT; w.target = U_IDLE;
         end
         U_START: begin
            w.cm = CM_WRITE; w.asel = A_START; w.wsel = W_VISITED; w.op = OP_START;
            w.emit = 1'b1; w.act = ACT_STARTED; w.jcond = J_ALWAYS; w.target = U_IDLE;
         end
         U_STEP: begin
            w.cm = CM_READ; w.asel = A_TOP; w.jcond = J_SKIP; w.target = U_NOP;
         end
         U_RD_N: begin
            w.cm = CM_READ; w.asel = A_N; w.cap = CAP_TOP;
         end
         U_RD_E: begin
            w.cm = CM_READ; w.asel = A_E; w.cap = CAP_N;
         end
         U_RD_S: begin
            w.cm = CM_READ; w.asel = A_S; w.cap = CAP_E;
         end
         U_RD_W: begin
            w.cm = CM_READ; w.asel = A_W; w.cap = CAP_S;
         end
         U_CAP_W: begin
            w.cap = CAP_W;
         end
         U_CHOOSE: begin
            w.op = OP_CHOOSE; w.jcond = J_MASK_ZERO; w.target = U_POP;
         end
         U_WR_NB: begin
            w.cm = CM_WRITE; w.asel = A_NB; w.wsel = W_NB;
         end
         U_WR_TOP: begin
            w.cm = CM_WRITE; w.asel = A_TOP; w.wsel = W_TOP; w.op = OP_PUSH;
            w.emit = 1'b1; w.act = ACT_CARVED; w.jcond = J_ALWAYS; w.target = U_IDLE;
         end
         U_POP: begin
            w.op = OP_POP_RD;
         end
         U_POP_LD: begin
            w.op = OP_POP_LD; w.emit = 1'b1; w.act = ACT_BACKTRACK;
            w.jcond = J_ALWAYS; w.target = U_IDLE;
         end
         U_READ: begin
            w.cm = CM_READ; w.asel = A_READ;
         end
         U_RD_ANS: begin
            w.op = OP_RD_ANS; w.emit = 1'b1; w.act = ACT_READ;
            w.jcond = J_ALWAYS; w.target = U_IDLE;
         end
         U_NOP: begin
            w.emit = 1'b1; w.act = ACT_NOP; w.jcond = J_ALWAYS; w.target = U_IDLE;
         end
         default: ;
      endcase
      return w;
   endfunction

   // avail bit order N, E, S, W; r is the low two bits of the random word, m3 the word's value mod 3
   function automatic logic [1:0] pick_dir(input logic [3:0] avail,
                                           input logic [1:0] r,
                                           input logic [1:0] m3);
      logic [2:0] n;
      logic [1:0] k;
      logic [2:0] seen;
      logic [1:0] d;
      n = 3'(avail[0]) + 3'(avail[1]) + 3'(avail[2]) + 3'(avail[3]);
      case (n)
         3'd1:    k = 2'd0;
         3'd2:    k = {1'b0, r[0]};
         3'd3:    k = m3;
         default: k = r;
      endcase
      d    = DIR_N;
      seen = 3'd0;
      for (int i = 0; i < 4; i++) begin
         if (avail[i] && seen == {1'b0, k}) d = 2'(i);
         if (avail[i]) seen = seen + 3'd1;
      end
      return d;
   endfunction

   function automatic logic [4:0] dir_bits(input logic [1:0] dir);
      logic [4:0] b;
      case (dir)
         DIR_N:   b = OPEN_N;
         DIR_E:   b = OPEN_E;
         DIR_S:   b = OPEN_S;
         default: b = OPEN_W;
      endcase
      return b;
   endfunction

   function automatic logic [4:0] opp_bits(input logic [1:0] dir);
      logic [4:0] b;
      case (dir)
         DIR_N:   b = OPEN_S;
         DIR_E:   b = OPEN_W;
         DIR_S:   b = OPEN_N;
         default: b = OPEN_E;
      endcase
      return b;
   endfunction

endpackage

[design/rdmc_useq.sv]
module rdmc_useq (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [1:0]            req_command,
   input  rdmc_pkg::ucond_type   cond,
   output logic                  busy,
   output rdmc_pkg::uword_type   uw
);
   import rdmc_pkg::*;

   logic [UPC_W-1:0] upc_ff, upc_in;
   logic             boot_ff, boot_in;

   assign uw   = ucode(upc_ff);
   assign busy = (upc_ff != U_IDLE);

   always_comb begin
      upc_in  = upc_ff + UPC_W'(1);
      boot_in = boot_ff;
      case (uw.jcond)
         J_NEXT: ;
         J_ALWAYS: upc_in = uw.target;
         J_CLR_MORE: begin
            if (cond.clr_more) upc_in = uw.target;
         end
         J_BOOT: begin
            boot_in = 1'b0;
            if (boot_ff) upc_in = uw.target;
         end
         J_SKIP: begin
            if (cond.skip) upc_in = uw.target;
         end
         J_MASK_ZERO: begin
            if (cond.mask_zero) upc_in = uw.target;
         end
         default: ;
      endcase
      if (upc_ff == U_IDLE) begin
         upc_in = U_IDLE;
         if (start) begin
            case (req_command)
               CMD_START: upc_in = U_CLR;
               CMD_STEP:  upc_in = U_STEP;
               CMD_READ:  upc_in = U_READ;
               default:   upc_in = U_NOP;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         upc_ff  <= U_CLR;
         boot_ff <= 1'b1;
      end else begin
         upc_ff  <= upc_in;
         boot_ff <= boot_in;
      end
   end

endmodule

[design/random_dfs_maze_carver.sv]
// Maze carver by randomized depth-first search over a MAZE_SIDE x MAZE_SIDE grid. A command
// is taken when start is high and busy is low; its single result beat appears on the rsp_
// ports, marked by rsp_valid for one cycle, and cannot be stalled. Every cell access goes
// through one single-port cell store, sequenced by a microcode table, so command latency is
// set by that port. A step returns a carve or a backtrack, a step after completion or
// before any start returns a no-op, as does an unused command, a read returns the cell
// answer, and a start sweeps the store to zero one cell per cycle. After reset the same
// sweep runs with busy high. Busy stays high while a command runs, so no new command is
// taken before the result beat of the one in progress.
module random_dfs_maze_carver #(
   parameter int MAZE_SIDE = rdmc_pkg::DEF_MAZE_SIDE
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [1:0]        req_command,
   input  logic [3:0]        req_start_x,
   input  logic [3:0]        req_start_y,
   input  logic [15:0]       req_random_word,
   input  logic [3:0]        req_cell_x,
   input  logic [3:0]        req_cell_y,
   output logic              rsp_valid,
   output logic [2:0]        rsp_action,
   output logic [3:0]        rsp_cur_x,
   output logic [3:0]        rsp_cur_y,
   output logic              rsp_maze_done,
   output logic signed [4:0] rsp_cell_code,
   output logic              rsp_cell_seen
);
   import rdmc_pkg::*;

   localparam int CELLS = MAZE_SIDE * MAZE_SIDE;
   localparam int CW    = $clog2(MAZE_SIDE);
   localparam int IDX_W = $clog2(CELLS);
   localparam int CNT_W = $clog2(CELLS + 1);
   localparam logic [CW-1:0] SIDE_MAX = CW'(MAZE_SIDE - 1);

   typedef logic [CW-1:0]    coord_type;
   typedef logic [IDX_W-1:0] addr_type;

   function automatic coord_type clamp_c(input logic [3:0] v);
      if (int'(v) >= MAZE_SIDE) return SIDE_MAX;
      return CW'(v);
   endfunction

   function automatic addr_type caddr(input coord_type y, input coord_type x);
      return IDX_W'(int'(y) * MAZE_SIDE + int'(x));
   endfunction

   uword_type uw;
   ucond_type cond;
   logic      accept;

   // request latch
   coord_type   sx_ff, sy_ff, rx_ff, ry_ff;
   logic        rin_ff;
   logic [15:0] rand_ff;
   logic [31:0] prod_ff;
   logic [1:0]  mod3_ff;
   logic [15:0] q3;

   // datapath
   logic [IDX_W-1:0] clr_ff, clr_in;
   logic [CNT_W-1:0] depth_ff, depth_in, visited_ff, visited_in, dm2;
   coord_type        tx_ff, tx_in, ty_ff, ty_in, nbx_ff, nbx_in, nby_ff, nby_in;
   logic [3:0]       topcell_ff, topcell_in, avail_ff, avail_in;
   logic [1:0]       dir_ff, dir_in;
   logic             has_n, has_e, has_s, has_w, done;
   addr_type         addr_top, ma;
   logic [4:0]       wd;

   // result
   logic              rsp_valid_ff, rsp_valid_in;
   logic [2:0]        act_ff, act_in;
   logic signed [4:0] code_ff, code_in;
   logic              vis_ff, vis_in;

   // stores
   logic [4:0]      cell_mem [CELLS];
   logic [4:0]      crd_ff;
   logic [2*CW-1:0] stk_mem [CELLS];
   logic [2*CW-1:0] srd_ff, stk_wd;
   addr_type        stk_wa;
   logic            stk_we;

   assign accept = start & ~busy;

   rdmc_useq u_seq (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_command (req_command),
      .cond        (cond),
      .busy        (busy),
      .uw          (uw)
   );

   assign done   = (visited_ff >= CNT_W'(CELLS));
   assign has_n  = (ty_ff != '0);
   assign has_e  = (tx_ff != SIDE_MAX);
   assign has_s  = (ty_ff != SIDE_MAX);
   assign has_w  = (tx_ff != '0);
   assign dm2    = depth_ff - CNT_W'(2);
   assign q3     = 16'(prod_ff[31:RECIP3_SHIFT]) * 16'd3;

   assign cond.clr_more  = (clr_ff != IDX_W'(CELLS - 1));
   assign cond.skip      = done || (depth_ff == '0);
   assign cond.mask_zero = (avail_ff == 4'd0);

   assign addr_top = caddr(ty_ff, tx_ff);

   always_comb begin
      case (uw.asel)
         A_CLR:   ma = clr_ff;
         A_START: ma = caddr(sy_ff, sx_ff);
         A_N:     ma = has_n ? caddr(ty_ff - CW'(1), tx_ff) : addr_top;
         A_E:     ma = has_e ? caddr(ty_ff, tx_ff + CW'(1)) : addr_top;
         A_S:     ma = has_s ? caddr(ty_ff + CW'(1), tx_ff) : addr_top;
         A_W:     ma = has_w ? caddr(ty_ff, tx_ff - CW'(1)) : addr_top;
         A_NB:    ma = caddr(nby_ff, nbx_ff);
         A_READ:  ma = caddr(ry_ff, rx_ff);
         default: ma = addr_top;
      endcase
      case (uw.wsel)
         W_ZERO:    wd = 5'd0;
         W_VISITED: wd = VISIT_MARK;
         W_NB:      wd = VISIT_MARK | opp_bits(dir_ff);
         default:   wd = VISIT_MARK | {1'b0, topcell_ff} | dir_bits(dir_ff);
      endcase
   end

   always_comb begin
      stk_we = 1'b0;
      stk_wa = '0;
      stk_wd = {sy_ff, sx_ff};
      if (uw.op == OP_START) begin
         stk_we = 1'b1;
      end else if (uw.op == OP_PUSH) begin
         stk_we = 1'b1;
         stk_wa = depth_ff[IDX_W-1:0];
         stk_wd = {nby_ff, nbx_ff};
      end
   end

   always_comb begin
      clr_in       = clr_ff;
      depth_in     = depth_ff;
      visited_in   = visited_ff;
      tx_in        = tx_ff;
      ty_in        = ty_ff;
      topcell_in   = topcell_ff;
      avail_in     = avail_ff;
      dir_in       = dir_ff;
      nbx_in       = nbx_ff;
      nby_in       = nby_ff;
      rsp_valid_in = uw.emit;
      act_in       = act_ff;
      code_in      = code_ff;
      vis_in       = vis_ff;
      if (uw.emit) begin
         act_in  = uw.act;
         code_in = '0;
         vis_in  = 1'b0;
      end
      case (uw.cap)
         CAP_TOP: topcell_in      = crd_ff[3:0];
         CAP_N:   avail_in[DIR_N] = has_n & ~crd_ff[4];
         CAP_E:   avail_in[DIR_E] = has_e & ~crd_ff[4];
         CAP_S:   avail_in[DIR_S] = has_s & ~crd_ff[4];
         CAP_W:   avail_in[DIR_W] = has_w & ~crd_ff[4];
         default: ;
      endcase
      case (uw.op)
         OP_CLR_INC: clr_in = cond.clr_more ? clr_ff + IDX_W'(1) : '0;
         OP_START: begin
            tx_in      = sx_ff;
            ty_in      = sy_ff;
            depth_in   = CNT_W'(1);
            visited_in = CNT_W'(1);
         end
         OP_CHOOSE: begin
            dir_in = pick_dir(avail_ff, rand_ff[1:0], mod3_ff);
            nbx_in = tx_ff;
            nby_in = ty_ff;
            case (dir_in)
               DIR_N:   nby_in = ty_ff - CW'(1);
               DIR_E:   nbx_in = tx_ff + CW'(1);
               DIR_S:   nby_in = ty_ff + CW'(1);
               default: nbx_in = tx_ff - CW'(1);
            endcase
         end
         OP_PUSH: begin
            depth_in   = depth_ff + CNT_W'(1);
            visited_in = visited_ff + CNT_W'(1);
            tx_in      = nbx_ff;
            ty_in      = nby_ff;
         end
         OP_POP_RD: depth_in = depth_ff - CNT_W'(1);
         OP_POP_LD: {ty_in, tx_in} = srd_ff;
         OP_RD_ANS: begin
            code_in = rin_ff ? ({1'b0, crd_ff[3:0]} - 5'd1) : 5'h1F;
            vis_in  = rin_ff & crd_ff[4];
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         depth_ff     <= '0;
         visited_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_ff       <= clr_in;
         depth_ff     <= depth_in;
         visited_ff   <= visited_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      tx_ff      <= tx_in;
      ty_ff      <= ty_in;
      topcell_ff <= topcell_in;
      avail_ff   <= avail_in;
      dir_ff     <= dir_in;
      nbx_ff     <= nbx_in;
      nby_ff     <= nby_in;
      act_ff     <= act_in;
      code_ff    <= code_in;
      vis_ff     <= vis_in;
      prod_ff    <= 32'(rand_ff) * 32'(RECIP3);
      mod3_ff    <= 2'(rand_ff - q3);
      if (accept) begin
         sx_ff   <= clamp_c(req_start_x);
         sy_ff   <= clamp_c(req_start_y);
         rx_ff   <= clamp_c(req_cell_x);
         ry_ff   <= clamp_c(req_cell_y);
         rin_ff  <= (int'(req_cell_x) < MAZE_SIDE) && (int'(req_cell_y) < MAZE_SIDE);
         rand_ff <= req_random_word;
      end
   end

   always_ff @(posedge clock) begin
      if (uw.cm == CM_WRITE) cell_mem[ma] <= wd;
      if (uw.cm == CM_READ) crd_ff <= cell_mem[ma];
   end

   always_ff @(posedge clock) begin
      if (stk_we) stk_mem[stk_wa] <= stk_wd;
      if (uw.op == OP_POP_RD && depth_ff > CNT_W'(1)) srd_ff <= stk_mem[dm2[IDX_W-1:0]];
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_action    = act_ff;
   assign rsp_cur_x     = (depth_ff == '0) ? 4'd0 : 4'(tx_ff);
   assign rsp_cur_y     = (depth_ff == '0) ? 4'd0 : 4'(ty_ff);
   assign rsp_maze_done = done;
   assign rsp_cell_code = code_ff;
   assign rsp_cell_seen = vis_ff;

endmodule

[design/rdmc_checker.sv]
`include "assert_macros.svh"

module rdmc_checker (
   input logic              clock,
   input logic              reset,
   input logic              start,
   input logic              busy,
   input logic              rsp_valid,
   input logic [2:0]        rsp_action,
   input logic signed [4:0] rsp_cell_code,
   input logic              rsp_cell_seen,
   input logic              rsp_maze_done
);
   import rdmc_pkg::*;

   logic plain_beat, cell_quiet, started_beat;

   assign plain_beat   = rsp_valid && (rsp_action != ACT_READ);
   assign cell_quiet   = (rsp_cell_code == 5'sd0) && !rsp_cell_seen;
   assign started_beat = rsp_valid && (rsp_action == ACT_STARTED);

   // a result beat only appears once the command has finished
   `RDMC_ASSERT_SAME(a_beat_idle, clock, reset, rsp_valid, !busy)
   // an accepted command always occupies the block
   `RDMC_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   // one beat per command
   `RDMC_ASSERT_NEXT(a_single_beat, clock, reset, rsp_valid, !rsp_valid)
   // cell fields are zero except for read answers
   `RDMC_ASSERT_SAME(a_cell_zero, clock, reset, plain_beat, cell_quiet)
   // done only clears as a start completes
   `RDMC_ASSERT_NEXT(a_done_hold, clock, reset, rsp_maze_done, rsp_maze_done || started_beat)

endmodule

bind random_dfs_maze_carver rdmc_checker u_rdmc_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .rsp_valid     (rsp_valid),
   .rsp_action    (rsp_action),
   .rsp_cell_code (rsp_cell_code),
   .rsp_cell_seen (rsp_cell_seen),
   .rsp_maze_done (rsp_maze_done)
);
